[design/tlj_pkg.sv]
package tlj_pkg;

  localparam logic [7:0] SPACE_CHAR = 8'd32;

  // Register byte addresses.
  localparam logic [1:0] REG_MAX_WIDTH = 2'd0;

  typedef struct packed {
    logic [7:0] ch;
    logic       word_end;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       line_end;
    logic       text_done;
  } out_item_t;

endpackage

[design/text_line_justifier_top.sv]
// A character that does not end a word is taken in S_IDLE; a word end also has its
// stored letters copied into the line buffer in S_COPY, after the line is emitted if needed.
// Emitting a line starts with setup (S_PREP, the gap divider in S_DIV, first word load in
// S_WORD), then letters, spaces and word boundaries; no request is taken meanwhile.
// Reset (synchronous, active high) clears counters, state and sets max_width to 32;
// the memories keep their contents and are only read where written.
module text_line_justifier_top #(
  parameter int MAX_WIDTH = 32,
  parameter int MAX_WORDS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlj_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tlj_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int PW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_COPY  = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_WORD  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_AFTER = 7'b1000000
  } state_t;

  state_t state;

  logic [5:0] max_width;
  logic [LW-1:0] w_eff;
  always_comb begin
    if (max_width == 6'd0) w_eff = LW'(1);
    else if (32'(max_width) > MAX_WIDTH) w_eff = LW'(MAX_WIDTH);
    else w_eff = LW'(max_width);
  end

  assign pready = 1'b1;
  assign prdata = (paddr == tlj_pkg::REG_MAX_WIDTH) ? {26'd0, max_width} : 32'd0;

  logic [7:0]    line_mem [MAX_WIDTH];
  logic [7:0]    word_mem [MAX_WIDTH];
  logic [LW-1:0] wlen_mem [MAX_WORDS];

  logic [LW-1:0] line_letters, word_length, copy_idx, copy_len;
  logic [CW-1:0] line_words;
  logic          pend_final, pend_text, left_mode;
  logic [5:0]    gap_div, gap_mod;
  logic [CW-1:0] word_idx;
  logic [LW-1:0] letters_left, gap_left, cnt, pos;
  logic          in_gap, word_loaded;

  logic [7:0]    line_rd, word_rd;
  logic [LW-1:0] wlen_rd;

  logic          div_start, div_busy;
  logic [5:0]    div_q, div_r;

  tlj_divider u_div (
    .clk, .rst, .start(div_start),
    .dividend(6'(w_eff - line_letters)),
    .divisor(5'(line_words - CW'(1))),
    .busy(div_busy), .quotient(div_q), .remainder(div_r)
  );

  logic          out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  logic [LW-1:0] wl;
  assign wl = (word_length > w_eff) ? w_eff : word_length;

  logic [LW-1:0] eff_len;
  logic          ends;
  logic [LW-1:0] new_len;
  assign ends = in_data.word_end || in_data.text_end;
  assign new_len = (word_length < w_eff) ? word_length + LW'(1) : word_length;
  assign eff_len = (new_len > w_eff) ? w_eff : new_len;

  logic need_flush;
  assign need_flush = (line_words != '0) &&
      ((32'(line_words) + 32'(line_letters) + 32'(eff_len) > 32'(w_eff)) ||
       (32'(line_words) >= MAX_WORDS));

  logic          emit_chr;
  logic [7:0]    emit_val;
  logic          last_chr;
  logic          word_done;
  assign word_done = (word_idx >= line_words) || (32'(word_idx) >= MAX_WORDS);

  always_comb begin
    emit_chr = 1'b0;
    emit_val = tlj_pkg::SPACE_CHAR;
    if (state == S_EMIT && out_free && word_loaded) begin
      emit_chr = 1'b1;
      if (in_gap || word_done || letters_left == '0) emit_val = tlj_pkg::SPACE_CHAR;
      else emit_val = line_rd;
    end
  end
  assign last_chr = (cnt == w_eff - LW'(1));

  always_ff @(posedge clk) begin
    line_rd <= line_mem[pos[PW-1:0]];
    word_rd <= word_mem[copy_idx[PW-1:0]];
    wlen_rd <= wlen_mem[word_idx[WW-1:0]];
  end

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state        <= S_IDLE;
      max_width    <= 6'd32;
      line_letters <= '0;
      line_words   <= '0;
      word_length  <= '0;
      out_valid    <= 1'b0;
      word_loaded  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == tlj_pkg::REG_MAX_WIDTH) begin
        max_width <= pwdata[5:0];
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (word_length < w_eff) begin
              word_mem[word_length[PW-1:0]] <= in_data.ch;
              word_length <= word_length + LW'(1);
            end
            if (ends) begin
              copy_len   <= eff_len;
              pend_text  <= in_data.text_end;
              copy_idx   <= '0;
              if (need_flush) begin
                pend_final <= 1'b0;
                state      <= S_PREP;
              end else begin
                state      <= S_COPY;
              end
            end
          end
        end
        S_COPY: begin
          // One letter per cycle; word_rd is registered, so it holds the letter at the previous copy_idx.
          if (copy_idx != '0 && 32'(line_letters) < MAX_WIDTH) begin
            line_mem[line_letters[PW-1:0]] <= word_rd;
            line_letters <= line_letters + LW'(1);
          end
          if (copy_idx == copy_len) begin
            if (32'(line_words) < MAX_WORDS) begin
              wlen_mem[line_words[WW-1:0]] <= copy_len;
              line_words <= line_words + CW'(1);
            end
            word_length <= '0;
            if (pend_text) begin
              pend_final <= 1'b1;
              pend_text  <= 1'b0;
              state      <= S_PREP;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            copy_idx <= copy_idx + LW'(1);
          end
        end
        S_PREP: begin
          left_mode <= pend_final || line_words <= CW'(1) ||
                       (32'(line_letters) + 32'(line_words) - 1 > 32'(w_eff));
          div_start <= 1'b1;
          word_idx  <= '0;
          pos       <= '0;
          cnt       <= '0;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (!div_start && !div_busy) begin
            gap_div     <= div_q;
            gap_mod     <= div_r;
            word_loaded <= 1'b0;
            state       <= S_WORD;
          end
        end
        S_WORD: begin
          // wlen_rd now holds the length of word word_idx.
          letters_left <= word_done ? '0 : wlen_rd;
          if (word_idx == '0 || word_done) begin
            in_gap   <= 1'b0;
            gap_left <= '0;
          end else begin
            in_gap   <= 1'b1;
            gap_left <= left_mode ? LW'(1) :
                        LW'(gap_div) + ((6'(word_idx) <= gap_mod) ? LW'(1) : LW'(0));
          end
          word_loaded <= 1'b1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (in_gap && gap_left == '0) begin
            in_gap <= 1'b0;
          end else if (!in_gap && !word_done && letters_left == '0) begin
            word_idx    <= word_idx + CW'(1);
            word_loaded <= 1'b0;
            state       <= S_AFTER;
          end else if (emit_chr) begin
            out_valid          <= 1'b1;
            out_data.out_char  <= emit_val;
            out_data.line_end  <= last_chr;
            out_data.text_done <= last_chr && pend_final;
            cnt <= cnt + LW'(1);
            if (in_gap) gap_left <= gap_left - LW'(1);
            else if (!word_done) begin
              letters_left <= letters_left - LW'(1);
              pos          <= pos + LW'(1);
              // After the last letter the next word's length is fetched while waiting.
              if (letters_left == LW'(1)) word_idx <= word_idx + CW'(1);
              word_loaded  <= 1'b0;
              state        <= S_AFTER;
            end
            if (last_chr) begin
              line_letters <= '0;
              line_words   <= '0;
              state        <= pend_final ? S_IDLE : S_COPY;
              pend_final   <= 1'b0;
              copy_idx     <= '0;
            end
          end
        end
        S_AFTER: begin
          // Wait for the registered reads to follow the new read address.
          if (letters_left == '0 && !word_done && !in_gap) begin
            state <= S_WORD;
          end else begin
            word_loaded <= 1'b1;
            state       <= S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/tlj_divider.sv]
// Restoring divider, one quotient bit per cycle.
module tlj_divider (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [5:0] dividend,
  input  logic [4:0] divisor,
  output logic       busy,
  output logic [5:0] quotient,
  output logic [5:0] remainder
);

  logic [2:0] bit_cnt;
  logic [6:0] trial;

  assign trial = {remainder, quotient[5]} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      bit_cnt <= 3'd0;
    end else if (busy) begin
      if (bit_cnt == 3'd5) begin
        busy <= 1'b0;
      end
      bit_cnt <= bit_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      if (!trial[6]) begin
        remainder <= trial[5:0];
        quotient  <= {quotient[4:0], 1'b1};
      end else begin
        remainder <= {remainder[4:0], quotient[5]};
        quotient  <= {quotient[4:0], 1'b0};
      end
    end
  end

endmodule

[design/tlj_checker.sv]
module tlj_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tlj_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_done_has_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.text_done |-> out_data.line_end)
    else $error("text_done without line_end");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("request withdrawn before it was taken");

endmodule

bind text_line_justifier_top tlj_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
